/* rtl/lfra_pkg.sv */
package lfra_pkg;

  localparam int ROOM_W   = 7;
  localparam int CUST_W   = 8;
  localparam int CHUNK_W  = 8;
  localparam int CHUNK_SH = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOROOM = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN
  } fsm_t;

  typedef struct packed {
    logic                found;
    logic [CHUNK_SH-1:0] offset;
    logic [ROOM_W-1:0]   room;
  } scan_res_t;

endpackage

/* rtl/lfra_ram.sv */
module lfra_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lfra_scan.sv */
module lfra_scan
  import lfra_pkg::*;
#(
  parameter int IDX_W = 1
) (
  input  logic [CHUNK_W-1:0] chunk_bits,
  input  logic [IDX_W-1:0]   chunk_idx,
  input  logic [ROOM_W-1:0]  limit,
  output scan_res_t          res
);

  logic [ROOM_W-1:0] base;

  assign base = ROOM_W'({chunk_idx, {CHUNK_SH{1'b0}}});

  // Lowest available bit of the group wins; bits at or above the limit are ignored.
  always_comb begin
    res = '0;
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      if (chunk_bits[k] && ((base + ROOM_W'(k)) < limit)) begin
        res.found  = 1'b1;
        res.offset = CHUNK_SH'(k);
        res.room   = base + ROOM_W'(k) + ROOM_W'(1);
      end
    end
  end

endmodule

/* rtl/lowest_free_room_allocator_core.sv */
// Departure, duplicate arrival and bad customer: result strobe registered from S_LOOK.
// Arrival: S_LOOK, then S_SCAN over 1 to ceil(ROOMS/8) 8-room groups, then the strobe.
// A new request is taken in the cycle its predecessor's result is shown, so one
// request occupies the block until its result; the group scan lengthens arrivals.
// Synchronous active-low reset; afterwards a clearing pass writes zero to every entry
// of the assignment table, with busy high. Results cannot be stalled.
module lowest_free_room_allocator_core
  import lfra_pkg::*;
#(
  parameter int ROOMS     = 64,
  parameter int CUSTOMERS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ROOM_W-1:0] cfg_wr_data,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [CUST_W-1:0] in_customer,
  output logic              out_valid,
  output logic [ROOM_W-1:0] out_room,
  output logic [ROOM_W-1:0] out_occupancy,
  output logic [ROOM_W-1:0] out_peak,
  output logic [1:0]        out_status
);

  localparam int AW     = $clog2(CUSTOMERS);
  localparam int NCHUNK = (ROOMS + CHUNK_W - 1) / CHUNK_W;
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IW     = CIW + CHUNK_SH;

  fsm_t                    state_r, state_nxt;
  logic                    kind_r;
  logic                    bad_r;
  logic [AW-1:0]           cust_r;
  logic [CIW-1:0]          chunk_r, chunk_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;
  logic [ROOMS-1:0]        free_r, free_nxt;
  logic [ROOM_W-1:0]       occ_r, occ_nxt;
  logic [ROOM_W-1:0]       peak_r, peak_nxt;
  logic [ROOM_W-1:0]       rooms_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [ROOM_W-1:0]       room_r, room_nxt;
  status_t                 status_r, status_nxt;

  logic                    accept;
  logic                    cust_bad;
  logic [ROOM_W-1:0]       limit;
  logic [NCHUNK*CHUNK_W-1:0] map_pad;
  logic [CHUNK_W-1:0]      chunk_bits;
  scan_res_t               scan_res;
  logic                    claim_en;
  logic                    rel_en;
  logic [IW-1:0]           claim_idx;
  logic [ROOM_W-1:0]       rel_idx;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ROOM_W-1:0]       ram_wdata;
  logic [ROOM_W-1:0]       ram_rdata;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cust_bad = ({24'd0, in_customer} >= 32'(CUSTOMERS));
  assign limit    = (rooms_r > ROOM_W'(ROOMS)) ? ROOM_W'(ROOMS) : rooms_r;

  for (genvar i = 0; i < NCHUNK * CHUNK_W; i++) begin : g_pad
    if (i < ROOMS) begin : g_room
      assign map_pad[i] = free_r[i];
    end else begin : g_fill
      assign map_pad[i] = 1'b0;
    end
  end

  assign chunk_bits = map_pad[{chunk_r, {CHUNK_SH{1'b0}}} +: CHUNK_W];
  assign claim_idx  = {chunk_r, scan_res.offset};
  assign rel_idx    = ram_rdata - ROOM_W'(1);

  lfra_scan #(
    .IDX_W (CIW)
  ) u_scan (
    .chunk_bits (chunk_bits),
    .chunk_idx  (chunk_r),
    .limit      (limit),
    .res        (scan_res)
  );

  lfra_ram #(
    .WIDTH (ROOM_W),
    .DEPTH (CUSTOMERS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (AW'(in_customer)),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      chunk_r     <= '0;
      clr_r       <= '0;
      free_r      <= '1;
      occ_r       <= '0;
      peak_r      <= '0;
      rooms_r     <= ROOM_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      occ_r       <= occ_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        rooms_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    room_r   <= room_nxt;
    status_r <= status_nxt;
    if (accept) begin
      kind_r <= in_kind;
      bad_r  <= cust_bad;
      cust_r <= AW'(in_customer);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chunk_nxt     = chunk_r;
    clr_nxt       = clr_r;
    free_nxt      = free_r;
    occ_nxt       = occ_r;
    peak_nxt      = peak_r;
    out_valid_nxt = 1'b0;
    room_nxt      = room_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = cust_r;
    ram_wdata     = '0;
    claim_en      = 1'b0;
    rel_en        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == AW'(CUSTOMERS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        room_nxt      = '0;
        status_nxt    = ST_OK;
        if (bad_r) begin
          status_nxt = kind_r ? ST_NOROOM : ST_FULL;
        end else if (kind_r) begin
          if ((ram_rdata == '0) || (ram_rdata > ROOM_W'(ROOMS))) begin
            status_nxt = ST_NOROOM;
          end else begin
            rel_en   = 1'b1;
            ram_we   = 1'b1;
            room_nxt = ram_rdata;
            if (occ_r != '0) begin
              occ_nxt = occ_r - ROOM_W'(1);
            end
          end
        end else if (ram_rdata != '0) begin
          status_nxt = ST_DUP;
        end else begin
          state_nxt     = S_SCAN;
          out_valid_nxt = 1'b0;
          chunk_nxt     = '0;
        end
      end
      S_SCAN: begin
        if (scan_res.found) begin
          claim_en      = 1'b1;
          ram_we        = 1'b1;
          ram_wdata     = scan_res.room;
          room_nxt      = scan_res.room;
          status_nxt    = ST_OK;
          occ_nxt       = occ_r + ROOM_W'(1);
          if ((occ_r + ROOM_W'(1)) > peak_r) begin
            peak_nxt = occ_r + ROOM_W'(1);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (chunk_r == CIW'(NCHUNK - 1)) begin
          room_nxt      = '0;
          status_nxt    = ST_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          chunk_nxt = chunk_r + CIW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    for (int i = 0; i < ROOMS; i++) begin
      if (claim_en && (IW'(i) == claim_idx)) begin
        free_nxt[i] = 1'b0;
      end
      if (rel_en && (ROOM_W'(i) == rel_idx)) begin
        free_nxt[i] = 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_room      = room_r;
  assign out_occupancy = occ_r;
  assign out_peak      = peak_r;
  assign out_status    = status_r;

`ifndef ASSERT_OFF
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the sequencer is busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r <= ROOM_W'(ROOMS)) && (peak_r >= occ_r))
    else $error("occupancy out of range or above peak");

  a_ok_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |-> (out_room != '0))
    else $error("successful request reported without a room");
`endif

endmodule
